@@ rtl/bsort_pkg.sv @@
// bsort_pkg: shared constants, command struct and run length helper
// for the bitonic sorter; no dependencies
package bsort_pkg;

    localparam int DATA_W          = 32;
    localparam int SIZE_W          = 3;
    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;
    localparam int SIZE_LOG2_MAX   = 6;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 3'd6;
    localparam logic              REG_SIZE_LOG2   = 1'b0;

    typedef struct packed {
        logic load;
        logic cmp;
        logic wr_hi;
        logic out_rd;
        logic out_last;
    } ctrl_cmd_t;

    // clamps the configured log2 size into the supported range
    function automatic logic [SIZE_W-1:0] run_log(input logic [SIZE_W-1:0] k,
                                                  input int max_log);
        logic [SIZE_W-1:0] r;
        r = k;
        if (r == '0)
        begin
            r = SIZE_W'(1);
        end
        if (int'(r) > SIZE_LOG2_MAX)
        begin
            r = SIZE_W'(SIZE_LOG2_MAX);
        end
        if (int'(r) > max_log)
        begin
            r = SIZE_W'(max_log);
        end
        return r;
    endfunction

endpackage

@@ rtl/bitonic_sort_power_of_two.sv @@
// bitonic_sort_power_of_two: top level, register port and sorter core
// depends on bsort_pkg, bsort_ctrl and bsort_dp
//
// channel   ports                                   transfer
// config    psel penable pwrite paddr pwdata prdata  psel & penable & pwrite & pready
// input     start busy value                         start & !busy
// result    result_valid sorted_value last           result_valid (one cycle each)
//
// one value is loaded per cycle while busy is low; the N-th value of a run
// starts the sort. a compare-exchange reads and compares and, on a swap, writes
// twice, as the element store has one write port; N/2 * log2(N)*(log2(N)+1)/2
// pairs. results stream out back to back, last on the final one. reset clears the
// run count and sets size_log2 to 6; results cannot be stalled.
module bitonic_sort_power_of_two #(
    parameter int MAX_ELEMENTS = bsort_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bsort_pkg::PADDR_W-1:0]        paddr,
    input  logic [bsort_pkg::PDATA_W-1:0]        pwdata,
    output logic [bsort_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [bsort_pkg::DATA_W-1:0]  value,
    output logic                                 result_valid,
    output logic signed [bsort_pkg::DATA_W-1:0]  sorted_value,
    output logic                                 last
);
    import bsort_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS + 1) - 1;
    localparam int LW = $clog2(AW + 1);

    logic [SIZE_W-1:0] size_log2_reg;
    logic [SIZE_W-1:0] size_log2_next;
    logic              cfg_wr;
    logic [SIZE_W-1:0] k_full;
    logic [LW-1:0]     k_eff;
    ctrl_cmd_t         cmd;
    logic [AW-1:0]     addr_a;
    logic [AW-1:0]     addr_b;
    logic              swap;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1] == REG_SIZE_LOG2);

    assign size_log2_next = cfg_wr ? pwdata[SIZE_W-1:0] : size_log2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= SIZE_LOG2_RESET;
        end
        else
        begin
            size_log2_reg <= size_log2_next;
        end
    end

    assign prdata = (paddr[PADDR_W-1] == REG_SIZE_LOG2)
                    ? PDATA_W'(size_log2_reg) : '0;

    assign k_full = run_log(size_log2_reg, AW);
    assign k_eff  = LW'(k_full);

    bsort_ctrl #(
        .AW (AW),
        .LW (LW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_clear (cfg_wr),
        .k_eff     (k_eff),
        .swap      (swap),
        .cmd       (cmd),
        .addr_a    (addr_a),
        .addr_b    (addr_b)
    );

    bsort_dp #(
        .AW (AW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .addr_a       (addr_a),
        .addr_b       (addr_b),
        .value        (value),
        .swap         (swap),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .last         (last)
    );

endmodule

@@ rtl/bsort_ram.sv @@
// bsort_ram: generic memory, one write port and two registered read ports
// no dependencies
module bsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata0 <= mem_reg[raddr0];
        rdata1 <= mem_reg[raddr1];
    end

endmodule

@@ rtl/bsort_dp.sv @@
// bsort_dp: element store, compare-exchange and result registers
// depends on bsort_pkg and bsort_ram
module bsort_dp #(
    parameter int AW = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bsort_pkg::ctrl_cmd_t      cmd,
    input  logic [AW-1:0]             addr_a,
    input  logic [AW-1:0]             addr_b,
    input  logic signed [bsort_pkg::DATA_W-1:0] value,
    output logic                      swap,
    output logic                      result_valid,
    output logic signed [bsort_pkg::DATA_W-1:0] sorted_value,
    output logic                      last
);
    import bsort_pkg::*;

    logic [DATA_W-1:0] rdata0;
    logic [DATA_W-1:0] rdata1;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] hold_reg;
    logic [DATA_W-1:0] hold_next;
    logic              valid_reg;
    logic              last_reg;

    bsort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2**AW)
    ) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (addr_a),
        .raddr1 (addr_b),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    // signed compare of the pair just read
    assign swap = cmd.cmp && ($signed(rdata0) > $signed(rdata1));

    assign we    = cmd.load || swap || cmd.wr_hi;
    assign waddr = cmd.wr_hi ? addr_b : addr_a;

    always_comb
    begin
        if (cmd.load)
        begin
            wdata = DATA_W'(value);
        end
        else if (cmd.wr_hi)
        begin
            wdata = hold_reg;
        end
        else
        begin
            wdata = rdata1;
        end
    end

    assign hold_next = cmd.cmp ? rdata0 : hold_reg;

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.out_rd;
            last_reg  <= cmd.out_last;
        end
    end

    assign result_valid = valid_reg;
    assign last         = last_reg;
    assign sorted_value = $signed(rdata0);

endmodule

@@ rtl/bsort_ctrl.sv @@
// bsort_ctrl: load, sort and output sequencer with the network loop counters
// depends on bsort_pkg
module bsort_ctrl #(
    parameter int AW = 6,
    parameter int LW = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 cfg_clear,
    input  logic [LW-1:0]        k_eff,
    input  logic                 swap,
    output bsort_pkg::ctrl_cmd_t cmd,
    output logic [AW-1:0]        addr_a,
    output logic [AW-1:0]        addr_b
);
    import bsort_pkg::*;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;
    logic [AW-1:0] t_reg;
    logic [AW-1:0] t_next;
    logic [LW-1:0] i_log_reg;
    logic [LW-1:0] i_log_next;
    logic [LW-1:0] m_log_reg;
    logic [LW-1:0] m_log_next;

    logic [AW-1:0] n_mask;
    logic [AW-1:0] t_last;
    logic [LW-1:0] m1;
    logic [AW-1:0] half;
    logic [AW-1:0] pos_p;
    logic [AW-1:0] pos_q;
    logic [AW-1:0] tsh;
    logic          desc;
    logic          advance;

    assign n_mask = {AW{1'b1}} >> (LW'(AW) - k_eff);
    assign t_last = n_mask >> 1;

    // pair positions: insert a zero bit at m/2 into t
    assign m1    = m_log_reg - LW'(1);
    assign half  = AW'(1) << m1;
    assign pos_p = ((t_reg >> m1) << m_log_reg) | (t_reg & (half - AW'(1)));
    assign pos_q = pos_p | half;
    assign tsh   = t_reg >> (i_log_reg - LW'(1));
    assign desc  = tsh[0];

    always_comb
    begin
        case (state_reg)
            S_LOAD:  addr_a = cnt_reg;
            S_OUT:   addr_a = cnt_reg;
            default: addr_a = desc ? pos_q : pos_p;
        endcase
        addr_b = desc ? pos_p : pos_q;
    end

    assign busy = (state_reg != S_LOAD);

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        t_next       = t_reg;
        i_log_next   = i_log_reg;
        m_log_next   = m_log_reg;
        advance      = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                if (cfg_clear)
                begin
                    cnt_next = '0;
                end
                else if (start)
                begin
                    cmd.load = 1'b1;
                    if (cnt_reg == n_mask)
                    begin
                        cnt_next   = '0;
                        t_next     = '0;
                        i_log_next = LW'(1);
                        m_log_next = LW'(1);
                        state_next = S_RD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
                if (swap)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_WR:
            begin
                cmd.wr_hi = 1'b1;
                advance   = 1'b1;
            end
            S_OUT:
            begin
                cmd.out_rd = 1'b1;
                cnt_next   = cnt_reg + AW'(1);
                if (cnt_reg == n_mask)
                begin
                    cmd.out_last = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (advance)
        begin
            state_next = S_RD;
            if (t_reg == t_last)
            begin
                t_next = '0;
                if (m_log_reg == LW'(1))
                begin
                    if (i_log_reg == k_eff)
                    begin
                        cnt_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        i_log_next = i_log_reg + LW'(1);
                        m_log_next = i_log_reg + LW'(1);
                    end
                end
                else
                begin
                    m_log_next = m_log_reg - LW'(1);
                end
            end
            else
            begin
                t_next = t_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            t_reg     <= '0;
            i_log_reg <= LW'(1);
            m_log_reg <= LW'(1);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            t_reg     <= t_next;
            i_log_reg <= i_log_next;
            m_log_reg <= m_log_next;
        end
    end

    a_load_to_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD && start && !cfg_clear && cnt_reg == n_mask)
        |=> (state_reg == S_RD))
        else $error("last load did not start the sort");

    a_last_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_last |-> (cmd.out_rd && cnt_reg == n_mask))
        else $error("last flag outside final output read");

    a_wr_after_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |-> ($past(state_reg) == S_CMP && $past(swap)))
        else $error("second write without a swap");

    a_out_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && cnt_reg != n_mask) |=> (state_reg == S_OUT))
        else $error("output run cut short");

endmodule

@@ tb/sv/testbench.sv @@
// testbench for bitonic_sort_power_of_two: apb setup of the run size, value loading
// and a self-checking scoreboard that predicts every sorted run
// depends on bsort_pkg and the bitonic_sort_power_of_two rtl
`timescale 1ns / 1ps

module testbench;

    import bsort_pkg::*;

    localparam int MAX_ELEMENTS = MAX_ELEMENTS_DEF;
    localparam logic [PADDR_W-1:0] ADDR_SIZE_LOG2 = PADDR_W'(4 * REG_SIZE_LOG2);
    localparam logic [PADDR_W-1:0] ADDR_SPARE     = PADDR_W'(4);
    localparam int RANDOM_VALUES = 100;

    typedef struct {
        logic signed [DATA_W-1:0] val;
        logic                     last;
    } sorted_entry_t;

    class sort_board;
        logic signed [DATA_W-1:0] run_store [MAX_ELEMENTS];
        logic [SIZE_W-1:0]        size_sel;
        int                       load_count;
        sorted_entry_t            sorted_due [$];
        int                       errors;
        int                       values_in;
        int                       runs_done;
        int                       results_seen;

        function new();
            size_sel     = SIZE_LOG2_RESET;
            load_count   = 0;
            errors       = 0;
            values_in    = 0;
            runs_done    = 0;
            results_seen = 0;
        endfunction

        function int run_len();
            int k;
            int n;
            k = int'(size_sel);
            if (k < 1)
            begin
                k = 1;
            end
            if (k > SIZE_LOG2_MAX)
            begin
                k = SIZE_LOG2_MAX;
            end
            n = 1 << k;
            while (n > MAX_ELEMENTS && n > 2)
            begin
                n = n >> 1;
            end
            return n;
        endfunction

        function void write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
            if ((addr >> 2) == PADDR_W'(REG_SIZE_LOG2))
            begin
                size_sel   = data[SIZE_W-1:0];
                load_count = 0;
            end
        endfunction

        function void order_pair(int lo_pos, int hi_pos);
            logic signed [DATA_W-1:0] a;
            logic signed [DATA_W-1:0] b;
            a = run_store[lo_pos];
            b = run_store[hi_pos];
            if (a > b)
            begin
                run_store[lo_pos] = b;
                run_store[hi_pos] = a;
            end
        endfunction

        function void bitonic_pass(int n);
            int half;
            int p;
            for (int i = 2; i <= n; i = i << 1)
            begin
                for (int m = i; m > 1; m = m >> 1)
                begin
                    half = m >> 1;
                    for (int t = 0; t < n / 2; t++)
                    begin
                        p = (t % half) + m * (t / half);
                        if ((t % i) < (i >> 1))
                        begin
                            order_pair(p, p + half);
                        end
                        else
                        begin
                            order_pair(p + half, p);
                        end
                    end
                end
            end
        endfunction

        function void note_value(logic signed [DATA_W-1:0] v);
            int            n;
            sorted_entry_t e;
            n = run_len();
            values_in++;
            if (load_count >= n)
            begin
                load_count = 0;
            end
            run_store[load_count % MAX_ELEMENTS] = v;
            load_count++;
            if (load_count < n)
            begin
                return;
            end
            bitonic_pass(n);
            for (int k = 0; k < n; k++)
            begin
                e.val  = run_store[k];
                e.last = (k == n - 1);
                sorted_due.push_back(e);
            end
            load_count = 0;
            runs_done++;
        endfunction

        task report(string what, logic signed [DATA_W-1:0] want,
                    logic signed [DATA_W-1:0] got);
            errors++;
            if (errors <= 40)
            begin
                $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what,
                         want, got);
            end
        endtask

        task check_result(logic signed [DATA_W-1:0] v, logic l);
            sorted_entry_t e;
            results_seen++;
            if (sorted_due.size() == 0)
            begin
                report("result transfer with nothing pending", 0, v);
                return;
            end
            e = sorted_due.pop_front();
            if (v !== e.val)
            begin
                report("sorted_value", e.val, v);
            end
            if (l !== e.last)
            begin
                report("last", DATA_W'(e.last), DATA_W'(l));
            end
        endtask

        function int pending();
            return sorted_due.size();
        endfunction
    endclass

    logic                      clk     = 1'b0;
    logic                      rst_n   = 1'b0;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [PADDR_W-1:0]        paddr   = '0;
    logic [PDATA_W-1:0]        pwdata  = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      start   = 1'b0;
    logic                      busy;
    logic signed [DATA_W-1:0]  value   = '0;
    logic                      result_valid;
    logic signed [DATA_W-1:0]  sorted_value;
    logic                      last;

    sort_board board;
    int        random_values;
    int        settings_used;

    bitonic_sort_power_of_two dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .last         (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            board.check_result(sorted_value, last);
        end
    end

    task automatic send_value(input logic signed [DATA_W-1:0] v);
        start <= 1'b1;
        value <= v;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        board.note_value(v);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_idle(input bit quiet);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            pause($urandom_range(1, 10));
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (board.pending() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        board.write_reg(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input logic [SIZE_W-1:0] k);
        logic [PDATA_W-1:0] data;
        data = $urandom();
        data[SIZE_W-1:0] = k;
        wait_idle();
        reg_write(ADDR_SIZE_LOG2, data);
        settings_used++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return DATA_W'($urandom_range(0, 6)) - 3;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [SIZE_W-1:0] k;
        int                n;
        int                runs;
        int                phase;
        bit                quiet;

        board = new();
        random_values = 0;
        settings_used = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // partial run at the reset size, then dropped by a size write
        send_value(32'sd17);
        send_value(-32'sd9);
        send_value(32'sd3);
        set_size(3'd1);
        send_value(32'sh8000_0000);
        send_value(32'sh7fff_ffff);
        send_value(32'sh7fff_ffff);
        send_value(32'sh8000_0000);
        set_size(3'd0);
        send_value(32'sd5);
        send_value(32'sd5);
        send_value(32'sd0);
        send_value(-32'sd1);
        set_size(3'd2);
        send_value(32'sd40);
        send_value(-32'sd40);
        wait_idle();
        reg_write(ADDR_SPARE, 32'hffff_ffff);
        send_value(32'sd0);
        send_value(32'sd7);
        send_value(32'sd11);
        send_value(32'sd12);
        set_size(3'd2);
        send_value(32'sh5555_5555);
        send_value(32'shaaaa_aaaa);
        send_value(32'sd0);
        send_value(-32'sd1);

        phase = 0;
        while (random_values < RANDOM_VALUES)
        begin
            if (phase == 0)
            begin
                k = 3'd7;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    7, 8: k = 3'd4;
                    9: k = SIZE_W'($urandom_range(5, 6));
                    default: k = SIZE_W'($urandom_range(0, 3));
                endcase
                // keep the run length near what is left of the value budget
                while (k > 3'd1 && (1 << k) > RANDOM_VALUES - random_values + 8)
                begin
                    k = k - SIZE_W'(1);
                end
            end
            set_size(k);
            n = board.run_len();
            runs = (n >= 32) ? 1 : $urandom_range(1, 3);
            while (runs > 1 && runs * n > RANDOM_VALUES - random_values)
            begin
                runs--;
            end
            quiet = ($urandom_range(0, 3) == 0);
            for (int r = 0; r < runs; r++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    maybe_idle(quiet || random_values >= RANDOM_VALUES * 4 / 5);
                    send_value(pick_value());
                    random_values++;
                end
            end
            if ($urandom_range(0, 3) == 0 && random_values < RANDOM_VALUES)
            begin
                for (int j = $urandom_range(1, (n > 8) ? 8 : n - 1); j > 0; j--)
                begin
                    send_value(pick_value());
                    random_values++;
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    wait_idle();
                    reg_write(ADDR_SPARE, $urandom());
                end
            end
            phase++;
        end

        wait_idle();
        repeat (16) @(posedge clk);
        $display("loaded %0d values in %0d size settings, %0d sorted runs",
                 board.values_in, settings_used, board.runs_done);
        $display("checked %0d result transfers, %0d mismatches",
                 board.results_seen, board.errors);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", board.pending());
        $display("status: fail");
        $finish;
    end

endmodule
